// ===== hw/rtl/wimudr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wimudr_pkg
// types and constants for the wheel and imu dead reckoning block
// ----------------------------------------------------------------------------
package wimudr_pkg;

  // one input beat
  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [63:0]        sample_time_us;
  } sample_t;

  // one result beat
  typedef struct packed {
    logic [63:0]        pose_time_us;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic signed [15:0] head_w;
    logic signed [15:0] head_x;
    logic signed [15:0] head_y;
    logic signed [15:0] head_z;
  } pose_t;

  // sequencer, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // steps of the run state
  localparam logic [3:0] SEQ_START = 4'd0;
  localparam logic [3:0] SEQ_ABS   = 4'd1;
  localparam logic [3:0] SEQ_DX    = 4'd2;
  localparam logic [3:0] SEQ_XX    = 4'd3;
  localparam logic [3:0] SEQ_ZZ    = 4'd4;
  localparam logic [3:0] SEQ_YZ    = 4'd5;
  localparam logic [3:0] SEQ_WX    = 4'd6;
  localparam logic [3:0] SEQ_DISP  = 4'd7;
  localparam logic [3:0] SEQ_LOX   = 4'd8;
  localparam logic [3:0] SEQ_HIX   = 4'd9;
  localparam logic [3:0] SEQ_RNDX  = 4'd10;
  localparam logic [3:0] SEQ_APX   = 4'd11;
  localparam logic [3:0] SEQ_RNDY  = 4'd12;
  localparam logic [3:0] SEQ_APY   = 4'd13;
  localparam logic [3:0] SEQ_RNDZ  = 4'd14;
  localparam logic [3:0] SEQ_APZ   = 4'd15;

  // 1.0 in q.28 for the forward direction
  localparam logic signed [33:0] DIR_ONE    = 34'sd268435456;
  // half of one q.16 lsb after the 12-bit shift
  localparam logic [65:0]        ROUND_BIAS = 66'd2048;
  localparam logic signed [47:0] POS_MAX    = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] POS_MIN    = 48'sh8000_0000_0000;

endpackage
`default_nettype wire

// ===== hw/rtl/wheel_imu_dead_reckoning.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wheel_imu_dead_reckoning
// wheel odometry step rotated by an imu quaternion, summed into a 3d position
// ----------------------------------------------------------------------------
//  channel  | signals                       | beat
//  ---------+-------------------------------+----------------------------------
//  sample   | sample_valid, sample_stall    | encoder counts, quaternion, time
//  pose     | pose_valid, pose_stall        | time, position, echoed heading
//  cfg      | cfg_valid, cfg_ready          | half_meters_per_count
//
//  one beat runs through accept, 16 sequencer steps and one emit step;
//  the step count is set by the 13 passes through the one 34x34 multiplier
//  rst (synchronous) clears position, previous counts and time, half_mpc,
//  state and pose_valid; sample_stall is high from accept until the result is
//  in the pose register, which holds a waiting beat while the next is taken
//  pose_stall only delays the emit step when the pose register is still full
// ----------------------------------------------------------------------------
module wheel_imu_dead_reckoning (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      sample_valid,
  output logic                     sample_stall,
  input  wire wimudr_pkg::sample_t sample,
  output logic                     pose_valid,
  input  wire                      pose_stall,
  output wimudr_pkg::pose_t        pose,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [31:0]              cfg_data
);
  import wimudr_pkg::*;

  // control
  state_t     state;
  logic [3:0] step;

  // model state
  logic [31:0]        half_mpc;
  logic [31:0]        prev_left;
  logic [31:0]        prev_right;
  logic [63:0]        prev_time;
  logic signed [47:0] pos [3];

  // working registers
  sample_t            item;
  logic [31:0]        delta_l;
  logic [31:0]        delta_r;
  logic signed [32:0] s_sum;
  logic [32:0]        s_mag;
  logic               s_neg;
  logic signed [32:0] acc_x;
  logic signed [33:0] acc_y;
  logic signed [32:0] acc_z;
  logic [32:0]        dir_mag [3];
  logic               dir_neg [3];
  logic [63:0]        disp;
  logic [31:0]        lo_high;
  logic [53:0]        m_step;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] prod;

  // handshakes
  logic accept;
  logic pose_take;
  logic emit_go;

  assign sample_stall = (state != ST_IDLE);
  assign cfg_ready    = (state == ST_IDLE);
  assign accept       = sample_valid && (state == ST_IDLE);
  assign pose_take    = pose_valid && !pose_stall;
  assign emit_go      = (state == ST_EMIT) && (!pose_valid || !pose_stall);

  // first beat after a zero time takes its own counts as the previous ones
  logic [31:0] base_l;
  logic [31:0] base_r;
  always_comb begin
    base_l = (prev_time == 64'd0) ? sample.left_count : prev_left;
    base_r = (prev_time == 64'd0) ? sample.right_count : prev_right;
  end

  // operand select per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step)
      SEQ_START: begin
        mul_a = 34'(item.quat_x);
        mul_b = 34'(item.quat_y);
      end
      SEQ_ABS: begin
        mul_a = 34'(item.quat_w);
        mul_b = 34'(item.quat_z);
      end
      SEQ_DX: begin
        mul_a = 34'(item.quat_x);
        mul_b = 34'(item.quat_x);
      end
      SEQ_XX: begin
        mul_a = 34'(item.quat_z);
        mul_b = 34'(item.quat_z);
      end
      SEQ_ZZ: begin
        mul_a = 34'(item.quat_y);
        mul_b = 34'(item.quat_z);
      end
      SEQ_YZ: begin
        mul_a = 34'(item.quat_w);
        mul_b = 34'(item.quat_x);
      end
      SEQ_WX: begin
        mul_a = {1'b0, s_mag};
        mul_b = {2'b00, half_mpc};
      end
      SEQ_LOX: begin
        mul_a = {2'b00, disp[31:0]};
        mul_b = {1'b0, dir_mag[0]};
      end
      SEQ_HIX: begin
        mul_a = {2'b00, disp[63:32]};
        mul_b = {1'b0, dir_mag[0]};
      end
      SEQ_RNDX: begin
        mul_a = {2'b00, disp[31:0]};
        mul_b = {1'b0, dir_mag[1]};
      end
      SEQ_APX: begin
        mul_a = {2'b00, disp[63:32]};
        mul_b = {1'b0, dir_mag[1]};
      end
      SEQ_RNDY: begin
        mul_a = {2'b00, disp[31:0]};
        mul_b = {1'b0, dir_mag[2]};
      end
      SEQ_APY: begin
        mul_a = {2'b00, disp[63:32]};
        mul_b = {1'b0, dir_mag[2]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // magnitudes of the direction terms, q.28
  logic signed [33:0] dx2;
  logic signed [33:0] dz2;
  logic [33:0]        dx_abs;
  logic [33:0]        dy_abs;
  logic [33:0]        dz_abs;
  logic [32:0]        s_abs;
  always_comb begin
    dx2    = {acc_x, 1'b0};
    dz2    = {acc_z, 1'b0};
    dx_abs = dx2[33] ? 34'(34'sd0 - dx2) : dx2;
    dy_abs = acc_y[33] ? 34'(34'sd0 - acc_y) : acc_y;
    dz_abs = dz2[33] ? 34'(34'sd0 - dz2) : dz2;
    s_abs  = s_sum[32] ? 33'(33'sd0 - s_sum) : s_sum;
  end

  // product of the high half plus carry-in from the low half, rounded to q.16
  logic [65:0] rnd_sum;
  assign rnd_sum = 66'(prod[63:0]) + 66'(lo_high) + ROUND_BIAS;

  // signed step into one axis with saturation
  logic [1:0]         ap_axis;
  logic signed [55:0] ap_pos;
  logic signed [55:0] ap_step;
  logic signed [55:0] ap_sum;
  logic signed [47:0] ap_res;
  always_comb begin
    case (step)
      SEQ_APX: ap_axis = 2'd0;
      SEQ_APY: ap_axis = 2'd1;
      default: ap_axis = 2'd2;
    endcase
    ap_pos  = 56'(pos[ap_axis]);
    ap_step = {2'b00, m_step};
    ap_sum  = (s_neg != dir_neg[ap_axis]) ? (ap_pos - ap_step) : (ap_pos + ap_step);
    if (!ap_sum[55] && (ap_sum[55:47] != 9'h000)) begin
      ap_res = POS_MAX;
    end else if (ap_sum[55] && (ap_sum[55:47] != 9'h1FF)) begin
      ap_res = POS_MIN;
    end else begin
      ap_res = ap_sum[47:0];
    end
  end

  // sequencer and model state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      step       <= SEQ_START;
      half_mpc   <= '0;
      prev_left  <= '0;
      prev_right <= '0;
      prev_time  <= '0;
      pos[0]     <= '0;
      pos[1]     <= '0;
      pos[2]     <= '0;
      pose_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        half_mpc <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            prev_left  <= sample.left_count;
            prev_right <= sample.right_count;
            prev_time  <= sample.sample_time_us;
            step       <= SEQ_START;
            state      <= ST_RUN;
          end
        end
        ST_RUN: begin
          case (step)
            SEQ_APX: pos[0] <= ap_res;
            SEQ_APY: pos[1] <= ap_res;
            SEQ_APZ: pos[2] <= ap_res;
            default: ;
          endcase
          step <= step + 4'd1;
          if (step == SEQ_APZ) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // pose register: emit wins over a take in the same cycle
      if (emit_go) begin
        pose_valid <= 1'b1;
      end else if (pose_take) begin
        pose_valid <= 1'b0;
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (accept) begin
      item    <= sample;
      delta_l <= sample.left_count - base_l;
      delta_r <= sample.right_count - base_r;
    end
    if (state == ST_RUN) begin
      case (step)
        SEQ_START: s_sum <= {delta_l[31], delta_l} + {delta_r[31], delta_r};
        SEQ_ABS: begin
          s_mag <= s_abs;
          s_neg <= s_sum[32];
          acc_x <= prod[32:0];
        end
        SEQ_DX: acc_x <= acc_x - prod[32:0];
        SEQ_XX: begin
          acc_y      <= prod[33:0];
          dir_mag[0] <= dx_abs[32:0];
          dir_neg[0] <= acc_x[32];
        end
        SEQ_ZZ: acc_y <= acc_y + prod[33:0];
        SEQ_YZ: begin
          acc_z <= prod[32:0];
          // forward y term: 1 - 2(x^2 + z^2)
          acc_y <= DIR_ONE - {acc_y[32:0], 1'b0};
        end
        SEQ_WX: begin
          acc_z      <= acc_z + prod[32:0];
          dir_mag[1] <= dy_abs[32:0];
          dir_neg[1] <= acc_y[33];
        end
        SEQ_DISP: begin
          disp       <= prod[63:0];
          dir_mag[2] <= dz_abs[32:0];
          dir_neg[2] <= acc_z[32];
        end
        SEQ_HIX, SEQ_APX, SEQ_APY: lo_high <= prod[63:32];
        SEQ_RNDX, SEQ_RNDY, SEQ_RNDZ: m_step <= rnd_sum[65:12];
        default: ;
      endcase
    end
    if (emit_go) begin
      pose.pose_time_us <= item.sample_time_us;
      pose.pos_x        <= pos[0];
      pose.pos_y        <= pos[1];
      pose.pos_z        <= pos[2];
      pose.head_w       <= item.quat_w;
      pose.head_x       <= item.quat_x;
      pose.head_y       <= item.quat_y;
      pose.head_z       <= item.quat_z;
    end
  end

endmodule
`default_nettype wire
